// File: rtl/zero_budget_prefix_block_decoder_assert.svh
// Assertion macros for the zero-budget prefix block decoder.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef ZERO_BUDGET_PREFIX_BLOCK_DECODER_ASSERT_SVH
`define ZERO_BUDGET_PREFIX_BLOCK_DECODER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define ZBPD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent, then consequent in the cycle after it.
`define ZBPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/zbpd_pkg.sv
// Package of the zero-budget prefix block decoder: widths, codes, internal structs,
// the prefix code table and the block continuation rule. Depends on nothing.
package zbpd_pkg;

    localparam int CODE_BITS       = 8;
    localparam int LEN_BITS        = 4;
    localparam int SYM_BITS        = 5;
    localparam int SYM_WIDTH_BITS  = 3;
    localparam int ZEROS_BITS      = 3;
    localparam int ZC_BITS         = 16;
    localparam int ZC_EXT_BITS     = ZC_BITS + 1;
    localparam int STREAM_BITS     = 24;
    localparam int STREAM_EXT_BITS = STREAM_BITS + 1;
    localparam int RESERVE_BITS    = 3;
    localparam int LEFT_BITS       = 4;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = 24;
    localparam int MIN_CODE_BITS   = 3;

    localparam logic [SYM_WIDTH_BITS-1:0] WIDTH_END = 3'd0;
    localparam logic [SYM_WIDTH_BITS-1:0] WIDTH_RAW = 3'd1;
    localparam logic [SYM_WIDTH_BITS-1:0] WIDTH_SYM = 3'd5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESERVE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AVAIL   = 2'd2;

    typedef struct packed {
        logic take;
        logic first;
        logic shift;
        logic code_bit;
    } pfx_ctrl_t;

    typedef struct packed {
        logic                  hit;
        logic [SYM_BITS-1:0]   sym;
        logic [ZEROS_BITS-1:0] zeros;
        logic [LEN_BITS-1:0]   len;
        logic [CODE_BITS-1:0]  bits;
    } pfx_stat_t;

    typedef struct packed {
        logic                 load;
        logic                 shift;
        logic [CODE_BITS-1:0] bits;
        logic [LEN_BITS-1:0]  len;
    } rp_ctrl_t;

    typedef struct packed {
        logic                head;
        logic [LEN_BITS-1:0] count;
    } rp_stat_t;

    typedef struct packed {
        logic                hit;
        logic [SYM_BITS-1:0] sym;
    } lookup_t;

    typedef struct packed {
        logic stop;
        logic err;
        logic tail;
    } nm_t;

    typedef struct packed {
        logic [SYM_BITS-1:0]       bits;
        logic [SYM_WIDTH_BITS-1:0] width;
        logic                      done;
        logic                      status;
        logic [LEFT_BITS-1:0]      left;
        logic                      last;
    } res_t;

    function automatic lookup_t code_lookup(input logic [LEN_BITS-1:0]  len,
                                            input logic [CODE_BITS-1:0] code);
        lookup_t r;
        r.hit = 1'b1;
        r.sym = '0;
        unique case ({len, code})
            {4'd3, 8'h00}: r.sym = 5'd0;
            {4'd4, 8'h02}: r.sym = 5'd1;
            {4'd4, 8'h03}: r.sym = 5'd2;
            {4'd4, 8'h04}: r.sym = 5'd4;
            {4'd4, 8'h05}: r.sym = 5'd8;
            {4'd4, 8'h06}: r.sym = 5'd16;
            {4'd5, 8'h0E}: r.sym = 5'd3;
            {4'd5, 8'h0F}: r.sym = 5'd6;
            {4'd5, 8'h10}: r.sym = 5'd5;
            {4'd5, 8'h11}: r.sym = 5'd12;
            {4'd5, 8'h12}: r.sym = 5'd10;
            {4'd5, 8'h13}: r.sym = 5'd9;
            {4'd5, 8'h14}: r.sym = 5'd24;
            {4'd5, 8'h15}: r.sym = 5'd20;
            {4'd5, 8'h16}: r.sym = 5'd18;
            {4'd5, 8'h17}: r.sym = 5'd17;
            {4'd5, 8'h18}: r.sym = 5'd28;
            {4'd5, 8'h19}: r.sym = 5'd25;
            {4'd5, 8'h1A}: r.sym = 5'd26;
            {4'd5, 8'h1B}: r.sym = 5'd7;
            {4'd6, 8'h38}: r.sym = 5'd11;
            {4'd6, 8'h39}: r.sym = 5'd13;
            {4'd6, 8'h3A}: r.sym = 5'd14;
            {4'd6, 8'h3B}: r.sym = 5'd19;
            {4'd6, 8'h3C}: r.sym = 5'd22;
            {4'd7, 8'h7A}: r.sym = 5'd21;
            {4'd7, 8'h7B}: r.sym = 5'd30;
            {4'd7, 8'h7C}: r.sym = 5'd29;
            {4'd7, 8'h7D}: r.sym = 5'd23;
            {4'd7, 8'h7E}: r.sym = 5'd15;
            {4'd8, 8'hFE}: r.sym = 5'd27;
            {4'd8, 8'hFF}: r.sym = 5'd31;
            default:       r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [ZEROS_BITS-1:0] zeros_in(input logic [SYM_BITS-1:0] sym);
        logic [ZEROS_BITS-1:0] z;
        z = '0;
        for (int i = 0; i < SYM_BITS; i++) begin
            z = z + ZEROS_BITS'(!sym[i]);
        end
        return z;
    endfunction

    // Decides whether a block stops, goes on with codewords or turns to raw bits.
    function automatic nm_t next_mode(input logic [ZC_BITS-1:0]      zc,
                                      input logic [ZC_BITS-1:0]      tgt,
                                      input logic [RESERVE_BITS-1:0] rsv,
                                      input logic                    room);
        nm_t r;
        r = '0;
        if (zc >= tgt) begin
            r.stop = 1'b1;
        end
        else if (rsv != '0) begin
            r.tail = ((ZC_EXT_BITS'(zc) + ZC_EXT_BITS'(rsv)) > ZC_EXT_BITS'(tgt)) || !room;
        end
        else if (!room) begin
            r.stop = 1'b1;
            r.err  = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: rtl/zbpd_if.sv
// Handshake channels of the zero-budget prefix block decoder: code bits in, results out.
// Depends on zbpd_pkg for the result field widths.
interface zbpd_code_if;
    logic valid;
    logic ready;
    logic code_bit;
    logic first;

    modport source (output valid, output code_bit, output first, input ready);
    modport sink (input valid, input code_bit, input first, output ready);
endinterface

interface zbpd_sym_if;
    import zbpd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [SYM_BITS-1:0]       sym_bits;
    logic [SYM_WIDTH_BITS-1:0] sym_width;
    logic                      done_res;
    logic                      status;
    logic [LEFT_BITS-1:0]      leftover_bits;
    logic                      last;

    modport source (output valid, output sym_bits, output sym_width, output done_res,
                    output status, output leftover_bits, output last, input ready);
    modport sink (input valid, input sym_bits, input sym_width, input done_res,
                  input status, input leftover_bits, input last, output ready);
endinterface

// File: rtl/zbpd_prefix.sv
// Prefix accumulator: shifts code bits into the codeword buffer and looks them up.
// Depends on zbpd_pkg for the code table and the control and status structs.
module zbpd_prefix (
    input  logic                clk,
    input  logic                rst_n,
    input  zbpd_pkg::pfx_ctrl_t ctrl,
    output zbpd_pkg::pfx_stat_t stat
);
    import zbpd_pkg::*;

    logic [CODE_BITS-1:0] buf_reg;
    logic [CODE_BITS-1:0] buf_next;
    logic [LEN_BITS-1:0]  len_reg;
    logic [LEN_BITS-1:0]  len_next;
    logic [CODE_BITS-1:0] base_buf;
    logic [LEN_BITS-1:0]  base_len;
    logic                 full;
    lookup_t              hit_info;

    always_comb
    begin
        base_buf = ctrl.first ? '0 : buf_reg;
        base_len = ctrl.first ? '0 : len_reg;
        buf_next = {base_buf[CODE_BITS-2:0], ctrl.code_bit};
        len_next = base_len + 1'b1;
        full     = len_next >= LEN_BITS'(CODE_BITS);
        hit_info = code_lookup(len_next, buf_next);

        stat.hit   = hit_info.hit;
        stat.sym   = hit_info.sym;
        stat.zeros = zeros_in(hit_info.sym);
        stat.len   = len_next;
        stat.bits  = buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            len_reg <= '0;
        end
        else if (ctrl.take)
        begin
            if (ctrl.shift && !hit_info.hit && !full)
            begin
                buf_reg <= buf_next;
                len_reg <= len_next;
            end
            else if (ctrl.shift || ctrl.first)
            begin
                buf_reg <= '0;
                len_reg <= '0;
            end
        end
    end

endmodule

// File: rtl/zbpd_replay.sv
// Replay shift register: hands out the bits of a dropped codeword one per cycle while shifted.
// Depends on zbpd_pkg for the replay control and status structs.
module zbpd_replay (
    input  logic               clk,
    input  logic               rst_n,
    input  zbpd_pkg::rp_ctrl_t ctrl,
    output zbpd_pkg::rp_stat_t stat
);
    import zbpd_pkg::*;

    logic [CODE_BITS-1:0] sr_reg;
    logic [LEN_BITS-1:0]  cnt_reg;

    assign stat.head  = sr_reg[CODE_BITS-1];
    assign stat.count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= ctrl.len;
        end
        else if (ctrl.shift)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // The codeword is left-aligned so that its first bit sits at the head.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sr_reg <= ctrl.bits << (LEN_BITS'(CODE_BITS) - ctrl.len);
        end
        else if (ctrl.shift)
        begin
            sr_reg <= {sr_reg[CODE_BITS-2:0], 1'b0};
        end
    end

endmodule

// File: rtl/zero_budget_prefix_block_decoder.sv
// Top level of the zero-budget prefix block decoder: block control, counters and result register.
// Depends on zbpd_pkg, zbpd_if, zbpd_prefix and zbpd_replay.
//
//   channel   direction  contents
//   stream    in         code_bit, first
//   result    out        sym_bits, sym_width, done_res, status, leftover_bits, last
//   cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// One bit is taken per cycle while ready; its result, if any, is registered in the next cycle.
// A codeword dropped with a nonzero reserve gives one raw bit result per replayed bit from the
// replay shift register, and no code bit is taken until that replay has ended.
// Reset clears all control state at once; there is no clearing pass.
// A bit is taken whenever no replay runs and the result register is empty or being emptied.
module zero_budget_prefix_block_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [zbpd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [zbpd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    zbpd_code_if.sink                          stream,
    zbpd_sym_if.source                         result
);
    import zbpd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_TAIL   = 4'b0100,
        ST_REPLAY = 4'b1000
    } state_t;

    state_t                    mode_reg;
    state_t                    mode_next;
    state_t                    eff_mode;
    logic [ZC_BITS-1:0]        zc_reg;
    logic [ZC_BITS-1:0]        zc_next;
    logic [STREAM_BITS-1:0]    bu_reg;
    logic [STREAM_BITS-1:0]    bu_next;
    logic [ZC_BITS-1:0]        target_reg;
    logic [RESERVE_BITS-1:0]   reserve_reg;
    logic [STREAM_BITS-1:0]    avail_reg;
    logic                      out_valid_reg;
    res_t                      out_reg;
    res_t                      res;
    logic                      res_load;

    logic                      slot_free;
    logic                      accept;
    logic [ZC_BITS-1:0]        eff_zc;
    logic [STREAM_BITS-1:0]    eff_bu;
    logic [STREAM_BITS-1:0]    bu_inc;
    logic                      room0;
    logic                      room1;
    nm_t                       m0;
    nm_t                       m1;
    logic [ZC_EXT_BITS-1:0]    nc;
    logic                      ok;
    logic [ZC_EXT_BITS-1:0]    tz;
    logic                      tdone;
    logic [ZC_EXT_BITS-1:0]    rz;
    logic                      rdone;

    pfx_ctrl_t                 pfx_ctrl;
    pfx_stat_t                 pfx;
    rp_ctrl_t                  rp_ctrl;
    rp_stat_t                  rp;

    zbpd_prefix u_prefix (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (pfx_ctrl),
        .stat  (pfx)
    );

    zbpd_replay u_replay (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rp_ctrl),
        .stat  (rp)
    );

    assign slot_free    = !out_valid_reg || result.ready;
    assign stream.ready = (mode_reg != ST_REPLAY) && slot_free;
    assign accept       = stream.valid && stream.ready;

    assign result.valid         = out_valid_reg;
    assign result.sym_bits      = out_reg.bits;
    assign result.sym_width     = out_reg.width;
    assign result.done_res      = out_reg.done;
    assign result.status        = out_reg.status;
    assign result.leftover_bits = out_reg.left;
    assign result.last          = out_reg.last;

    always_comb
    begin
        room0 = (STREAM_EXT_BITS'(MIN_CODE_BITS) + STREAM_EXT_BITS'(reserve_reg))
                <= STREAM_EXT_BITS'(avail_reg);
        m0    = next_mode('0, target_reg, reserve_reg, room0);

        if (stream.first)
        begin
            eff_zc = '0;
            eff_bu = '0;
            if (m0.stop)
            begin
                eff_mode = ST_IDLE;
            end
            else if (m0.tail)
            begin
                eff_mode = ST_TAIL;
            end
            else
            begin
                eff_mode = ST_DECODE;
            end
        end
        else
        begin
            eff_zc   = zc_reg;
            eff_bu   = bu_reg;
            eff_mode = mode_reg;
        end

        bu_inc = (eff_bu == {STREAM_BITS{1'b1}}) ? eff_bu : eff_bu + 1'b1;
        room1  = (STREAM_EXT_BITS'(bu_inc) + STREAM_EXT_BITS'(MIN_CODE_BITS)
                  + STREAM_EXT_BITS'(reserve_reg)) <= STREAM_EXT_BITS'(avail_reg);

        nc = ZC_EXT_BITS'(eff_zc) + ZC_EXT_BITS'(pfx.zeros);
        if (reserve_reg == '0)
        begin
            ok = nc <= ZC_EXT_BITS'(target_reg);
        end
        else
        begin
            ok = (nc + ZC_EXT_BITS'(reserve_reg)) <= ZC_EXT_BITS'(target_reg);
        end
        m1 = next_mode(nc[ZC_BITS-1:0], target_reg, reserve_reg, room1);

        tz    = ZC_EXT_BITS'(eff_zc) + ZC_EXT_BITS'(!stream.code_bit);
        tdone = tz >= ZC_EXT_BITS'(target_reg);
        rz    = ZC_EXT_BITS'(zc_reg) + ZC_EXT_BITS'(!rp.head);
        rdone = rz >= ZC_EXT_BITS'(target_reg);

        pfx_ctrl.take     = accept;
        pfx_ctrl.first    = stream.first;
        pfx_ctrl.shift    = (eff_mode == ST_DECODE);
        pfx_ctrl.code_bit = stream.code_bit;
    end

    always_comb
    begin
        mode_next     = mode_reg;
        zc_next       = zc_reg;
        bu_next       = bu_reg;
        res_load      = 1'b0;
        res           = '0;
        rp_ctrl.load  = 1'b0;
        rp_ctrl.shift = 1'b0;
        rp_ctrl.bits  = pfx.bits;
        rp_ctrl.len   = pfx.len;

        if (accept)
        begin
            if (stream.first)
            begin
                zc_next   = '0;
                bu_next   = '0;
                mode_next = eff_mode;
            end

            if (stream.first && m0.stop)
            begin
                res_load   = 1'b1;
                res.width  = WIDTH_END;
                res.done   = 1'b1;
                res.status = m0.err;
                res.left   = LEFT_BITS'(1);
                res.last   = 1'b1;
            end
            else
            begin
                unique case (eff_mode)
                    ST_DECODE:
                    begin
                        bu_next = bu_inc;
                        if (pfx.hit)
                        begin
                            if (ok)
                            begin
                                zc_next    = nc[ZC_BITS-1:0];
                                res_load   = 1'b1;
                                res.bits   = pfx.sym;
                                res.width  = WIDTH_SYM;
                                res.done   = m1.stop;
                                res.status = m1.err;
                                res.last   = 1'b1;
                                if (m1.stop)
                                begin
                                    mode_next = ST_IDLE;
                                end
                                else if (m1.tail)
                                begin
                                    mode_next = ST_TAIL;
                                end
                                else
                                begin
                                    mode_next = ST_DECODE;
                                end
                            end
                            else if (reserve_reg == '0)
                            begin
                                res_load  = 1'b1;
                                res.width = WIDTH_END;
                                res.done  = 1'b1;
                                res.left  = pfx.len;
                                res.last  = 1'b1;
                                mode_next = ST_IDLE;
                            end
                            else
                            begin
                                rp_ctrl.load = 1'b1;
                                mode_next    = ST_REPLAY;
                            end
                        end
                    end
                    ST_TAIL:
                    begin
                        bu_next   = bu_inc;
                        zc_next   = tz[ZC_BITS-1:0];
                        res_load  = 1'b1;
                        res.bits  = SYM_BITS'(stream.code_bit);
                        res.width = WIDTH_RAW;
                        res.done  = tdone;
                        res.last  = 1'b1;
                        if (tdone)
                        begin
                            mode_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        res_load = 1'b0;
                    end
                endcase
            end
        end
        else if ((mode_reg == ST_REPLAY) && slot_free)
        begin
            rp_ctrl.shift = 1'b1;
            zc_next       = rz[ZC_BITS-1:0];
            res_load      = 1'b1;
            res.bits      = SYM_BITS'(rp.head);
            res.width     = WIDTH_RAW;
            res.done      = rdone;
            res.left      = rdone ? rp.count - 1'b1 : '0;
            res.last      = rdone || (rp.count == LEFT_BITS'(1));
            if (rdone)
            begin
                mode_next = ST_IDLE;
            end
            else if (rp.count == LEFT_BITS'(1))
            begin
                mode_next = ST_TAIL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= ST_IDLE;
            zc_reg        <= '0;
            bu_reg        <= '0;
            target_reg    <= '0;
            reserve_reg   <= '0;
            avail_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            zc_reg   <= zc_next;
            bu_reg   <= bu_next;

            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TARGET:  target_reg  <= cfg_data[ZC_BITS-1:0];
                    CFG_RESERVE: reserve_reg <= cfg_data[RESERVE_BITS-1:0];
                    CFG_AVAIL:   avail_reg   <= cfg_data[STREAM_BITS-1:0];
                    default:     avail_reg   <= avail_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

endmodule

// File: rtl/zbpd_checker.sv
// Port-level checks on the result channel of the zero-budget prefix block decoder.
// Depends on zbpd_pkg and the assertion macros; bound to the top level below.
`include "zero_budget_prefix_block_decoder_assert.svh"

module zbpd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                valid,
    input logic                                ready,
    input logic [zbpd_pkg::SYM_BITS-1:0]       sym_bits,
    input logic [zbpd_pkg::SYM_WIDTH_BITS-1:0] sym_width,
    input logic                                done_res,
    input logic                                status,
    input logic [zbpd_pkg::LEFT_BITS-1:0]      leftover_bits,
    input logic                                last
);
    import zbpd_pkg::*;

    `ZBPD_ASSERT_IMPLY(a_left_done, valid && (leftover_bits != '0), done_res, "leftover bits reported before the block is done")
    `ZBPD_ASSERT_IMPLY(a_done_last, valid && done_res, last, "block finished on a transaction not marked last")
    `ZBPD_ASSERT_IMPLY(a_end_marker, valid && (sym_width == WIDTH_END), done_res && (sym_bits == '0), "end marker is not a clean block end")
    `ZBPD_ASSERT_IMPLY(a_raw_bit, valid && (sym_width == WIDTH_RAW), (sym_bits[SYM_BITS-1:1] == '0) && !status, "raw tail bit carries more than one bit or an error")
    `ZBPD_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(sym_bits) && $stable(sym_width) && $stable(done_res), "stalled result transaction changed")

endmodule

bind zero_budget_prefix_block_decoder zbpd_checker u_zbpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .valid         (result.valid),
    .ready         (result.ready),
    .sym_bits      (result.sym_bits),
    .sym_width     (result.sym_width),
    .done_res      (result.done_res),
    .status        (result.status),
    .leftover_bits (result.leftover_bits),
    .last          (result.last)
);
